@@ design/wfm_pkg.sv @@
// Shared types and constants for the wall-following maze walker.
// No dependencies; imported by the controller, the top level and the checker.

package wfm_pkg;

    localparam int GRID_SIDE = 16;
    localparam int COORD_W   = 4;
    localparam int ADDR_W    = 2 * COORD_W;
    localparam int CELLS     = GRID_SIDE * GRID_SIDE;
    localparam int CODE_W    = 3;
    localparam int HEAD_W    = 2;
    localparam int CMD_W     = 2;
    localparam int TRY_W     = 2;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CODE_W-1:0] CODE_OPEN = 3'd0;
    localparam logic [CODE_W-1:0] CODE_WALL = 3'd1;
    localparam logic [CODE_W-1:0] CODE_ONCE = 3'd2;
    localparam logic [CODE_W-1:0] CODE_MORE = 3'd3;
    localparam logic [CODE_W-1:0] CODE_MARK = 3'd4;

    localparam logic [HEAD_W-1:0] HEAD_RIGHT = 2'd0;
    localparam logic [HEAD_W-1:0] HEAD_DOWN  = 2'd1;
    localparam logic [HEAD_W-1:0] HEAD_LEFT  = 2'd2;
    localparam logic [HEAD_W-1:0] HEAD_UP    = 2'd3;

    localparam logic [TRY_W-1:0] TRY_RIGHT    = 2'd0;
    localparam logic [TRY_W-1:0] TRY_STRAIGHT = 2'd1;
    localparam logic [TRY_W-1:0] TRY_LEFT     = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_BEGIN = 2'd1,
        CMD_STEP  = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_ROW = 2'd0,
        REG_START_COL = 2'd1,
        REG_END_ROW   = 2'd2,
        REG_END_COL   = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PROBE,
        ST_CHECK,
        ST_TURN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [COORD_W-1:0] start_row;
        logic [COORD_W-1:0] start_col;
        logic [COORD_W-1:0] end_row;
        logic [COORD_W-1:0] end_col;
    } cfg_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [CODE_W-1:0] wdata;
    } ram_req_t;

    typedef struct packed {
        logic               status;
        logic               at_goal;
        logic [CODE_W-1:0]  here_code;
        logic [HEAD_W-1:0]  heading;
        logic [COORD_W-1:0] pos_col;
        logic [COORD_W-1:0] pos_row;
    } res_t;

    function automatic logic [CODE_W-1:0] mark_code(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] res;
        res = code;
        if (code == CODE_OPEN) begin
            res = CODE_ONCE;
        end else if (code == CODE_ONCE) begin
            res = CODE_MORE;
        end
        return res;
    endfunction

endpackage

@@ design/wfm_ram.sv @@
// Generic single-port RAM, one write or read per cycle, registered read data.
// No dependencies.

module wfm_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/wfm_ctrl.sv @@
// Command sequencer and walker state: probes neighbour cells through the grid RAM,
// moves, marks and writes back. Depends on wfm_pkg.

module wfm_ctrl import wfm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CMD_W-1:0]   command,
    input  logic [COORD_W-1:0] cell_row,
    input  logic [COORD_W-1:0] cell_col,
    input  logic [CODE_W-1:0]  cell_code,
    input  cfg_t               cfg,
    output ram_req_t           ram_req,
    input  logic [CODE_W-1:0]  ram_rdata,
    output logic               res_valid,
    input  logic               res_ready,
    output res_t               res
);

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [COORD_W-1:0] wrow_reg, wrow_next;
    logic [COORD_W-1:0] wcol_reg, wcol_next;
    logic [CODE_W-1:0]  wcode_reg, wcode_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [COORD_W-1:0] col_reg, col_next;
    logic [HEAD_W-1:0]  head_reg, head_next;
    logic               active_reg, active_next;
    logic [CODE_W-1:0]  here_reg, here_next;
    logic [TRY_W-1:0]   try_reg, try_next;
    logic               status_reg, status_next;

    logic [HEAD_W-1:0]  turn;
    logic [HEAD_W-1:0]  probe_dir;
    logic [COORD_W:0]   nb_row;
    logic [COORD_W:0]   nb_col;
    logic               nb_in;
    logic               nb_goal;
    logic               goal_here;
    logic               last_try;
    logic               nb_open;
    logic [CODE_W-1:0]  new_code;

    // candidate heading: right turn, straight, then left
    always_comb begin
        unique case (try_reg)
            TRY_RIGHT:    turn = 2'd1;
            TRY_STRAIGHT: turn = 2'd0;
            TRY_LEFT:     turn = 2'd3;
            default:      turn = 2'd0;
        endcase
        probe_dir = head_reg + turn;
        nb_row = {1'b0, row_reg};
        nb_col = {1'b0, col_reg};
        unique case (probe_dir)
            HEAD_RIGHT: nb_col = {1'b0, col_reg} + (COORD_W+1)'(1);
            HEAD_DOWN:  nb_row = {1'b0, row_reg} + (COORD_W+1)'(1);
            HEAD_LEFT:  nb_col = {1'b0, col_reg} - (COORD_W+1)'(1);
            HEAD_UP:    nb_row = {1'b0, row_reg} - (COORD_W+1)'(1);
            default:    nb_row = {1'b0, row_reg};
        endcase
    end

    // off-grid neighbours wrap to values at or above the side length
    assign nb_in     = (nb_row < (COORD_W+1)'(GRID_SIDE)) &&
                       (nb_col < (COORD_W+1)'(GRID_SIDE));
    assign nb_goal   = (nb_row[COORD_W-1:0] == cfg.end_row) &&
                       (nb_col[COORD_W-1:0] == cfg.end_col);
    assign goal_here = (row_reg == cfg.end_row) && (col_reg == cfg.end_col);
    assign last_try  = (try_reg == TRY_LEFT);
    assign nb_open   = (ram_rdata != CODE_WALL);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (cmd_reg == CMD_STEP && active_reg && !goal_here) begin
                    state_next = ST_PROBE;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_PROBE: begin
                if (nb_in) begin
                    state_next = ST_CHECK;
                end else if (last_try) begin
                    state_next = ST_TURN;
                end
            end
            ST_CHECK: begin
                if (nb_open) begin
                    state_next = ST_DONE;
                end else if (last_try) begin
                    state_next = ST_TURN;
                end else begin
                    state_next = ST_PROBE;
                end
            end
            ST_TURN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory port
    always_comb begin
        cmd_next      = cmd_reg;
        wrow_next     = wrow_reg;
        wcol_next     = wcol_reg;
        wcode_next    = wcode_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        head_next     = head_reg;
        active_next   = active_reg;
        here_next     = here_reg;
        try_next      = try_reg;
        status_next   = status_reg;
        new_code      = CODE_MARK;
        ram_req.we    = 1'b0;
        ram_req.addr  = {row_reg, col_reg};
        ram_req.wdata = CODE_MARK;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd_next   = cmd_t'(command);
                    wrow_next  = cell_row;
                    wcol_next  = cell_col;
                    wcode_next = cell_code;
                end
            end
            ST_EXEC: begin
                status_next = 1'b0;
                try_next    = TRY_RIGHT;
                unique case (cmd_reg)
                    CMD_WRITE: begin
                        ram_req.we    = 1'b1;
                        ram_req.addr  = {wrow_reg, wcol_reg};
                        ram_req.wdata = wcode_reg;
                        if (wrow_reg == row_reg && wcol_reg == col_reg) begin
                            here_next = wcode_reg;
                        end
                    end
                    CMD_BEGIN: begin
                        row_next      = cfg.start_row;
                        col_next      = cfg.start_col;
                        head_next     = HEAD_RIGHT;
                        active_next   = 1'b1;
                        here_next     = CODE_MARK;
                        ram_req.we    = 1'b1;
                        ram_req.addr  = {cfg.start_row, cfg.start_col};
                        ram_req.wdata = CODE_MARK;
                    end
                    CMD_STEP: begin
                        status_next = !active_reg;
                    end
                    default: begin
                        status_next = 1'b0;
                    end
                endcase
            end
            ST_PROBE: begin
                ram_req.addr = {nb_row[COORD_W-1:0], nb_col[COORD_W-1:0]};
                if (!nb_in) begin
                    try_next = try_reg + TRY_W'(1);
                end
            end
            ST_CHECK: begin
                if (nb_open) begin
                    new_code      = nb_goal ? CODE_MARK : mark_code(ram_rdata);
                    row_next      = nb_row[COORD_W-1:0];
                    col_next      = nb_col[COORD_W-1:0];
                    head_next     = probe_dir;
                    here_next     = new_code;
                    ram_req.we    = 1'b1;
                    ram_req.addr  = {nb_row[COORD_W-1:0], nb_col[COORD_W-1:0]};
                    ram_req.wdata = new_code;
                end else begin
                    try_next = try_reg + TRY_W'(1);
                end
            end
            ST_TURN: begin
                new_code      = mark_code(here_reg);
                head_next     = head_reg + HEAD_LEFT;
                here_next     = new_code;
                ram_req.we    = 1'b1;
                ram_req.wdata = new_code;
            end
            ST_DONE: begin
                status_next = status_reg;
            end
            default: begin
                status_next = status_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            row_reg    <= '0;
            col_reg    <= '0;
            head_reg   <= HEAD_RIGHT;
            active_reg <= 1'b0;
            status_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            head_reg   <= head_next;
            active_reg <= active_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        wrow_reg  <= wrow_next;
        wcol_reg  <= wcol_next;
        wcode_reg <= wcode_next;
        here_reg  <= here_next;
        try_reg   <= try_next;
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign res_valid     = (state_reg == ST_DONE);
    assign res.pos_row   = row_reg;
    assign res.pos_col   = col_reg;
    assign res.heading   = head_reg;
    assign res.here_code = here_reg;
    assign res.at_goal   = goal_here;
    assign res.status    = status_reg;

endmodule

@@ design/wall_follower_maze_walker.sv @@
// Right-hand wall-following maze walker on a 16 x 16 grid held in one RAM.
// Writes, begins and ignored steps go from execute straight to the registered result; a step
// probes neighbours, reading each on-grid one from the RAM, and turns back if none is open.
// One item at a time: the sequencer is ready for the next in the cycle after the result is
// registered; the output register frees the sequencer.
// Synchronous active-low reset clears walker, configuration and handshake state, not the grid.

module wall_follower_maze_walker import wfm_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // cell_row, cell_col, cell_code, zero pad
    input  logic [CMD_W-1:0]     s_tuser,   // command
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // pos_row, pos_col, heading, here_code,
                                            // at_goal, zero pad
    output logic                 m_tuser,   // status
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data
);

    cfg_t              cfg_reg, cfg_next;
    res_t              out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    ram_req_t          ram_req;
    logic [CODE_W-1:0] ram_rdata;
    res_t              res;
    logic              res_valid;
    logic              res_ready;

    assign cfg_ready = 1'b1;
    assign res_ready = !out_valid_reg || m_tready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_START_ROW: cfg_next.start_row = cfg_data;
                REG_START_COL: cfg_next.start_col = cfg_data;
                REG_END_ROW:   cfg_next.end_row   = cfg_data;
                REG_END_COL:   cfg_next.end_col   = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready) begin
            out_next       = res;
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    wfm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .command   (s_tuser),
        .cell_row  (s_tdata[3:0]),
        .cell_col  (s_tdata[7:4]),
        .cell_code (s_tdata[10:8]),
        .cfg       (cfg_reg),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    wfm_ram #(
        .WIDTH (CODE_W),
        .DEPTH (CELLS)
    ) u_grid (
        .aclk  (aclk),
        .we    (ram_req.we),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.at_goal, out_reg.here_code, out_reg.heading,
                       out_reg.pos_col, out_reg.pos_row};
    assign m_tuser  = out_reg.status;

endmodule

@@ design/wfm_checker.sv @@
// Port-level checks for the maze walker, attached by bind.
// Depends on wfm_pkg and the top level's ports.

module wfm_checker import wfm_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // ignored step means no walk yet: walker still at origin facing right
    a_ignored_at_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[9:0] == '0)
        else $error("ignored step with walker moved");

    // one item in work at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind wall_follower_maze_walker wfm_checker u_wfm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
